@@ sv/scpr_pkg.sv @@
// Shared constants and types of the second-chance page replacement unit.
package scpr_pkg;

   localparam int FRAMES_DEF    = 64;
   localparam int PAGE_BITS_DEF = 20;

   // Capacity register: fixed field width and reset value.
   localparam int          CAP_W     = 7;
   localparam logic [6:0]  CAP_RESET = 7'd64;

   // Configuration port geometry and register index.
   localparam int          CSR_ADDR_W   = 3;
   localparam int          CSR_DATA_W   = 32;
   localparam logic        REG_CAPACITY = 1'b0;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic clear;
      logic compare;
      logic sweep;
   } cell_cmd_type;

   // Status reported by each cell to the controller.
   typedef struct packed {
      logic match;
      logic found;
      logic occupied;
   } cell_stat_type;

endpackage

@@ sv/scpr_ram.sv @@
// Generic single-port-write, registered-read RAM.
module scpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/scpr_cell.sv @@
// One frame cell: page tag, valid and visited bits, and the hand token.
module scpr_cell #(
   parameter int IDX       = 0,
   parameter int PAGE_BITS = 20,
   parameter int SLOT_W    = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  scpr_pkg::cell_cmd_type   cmd,
   input  logic [PAGE_BITS-1:0]     page_in,
   input  logic [SLOT_W-1:0]        last_idx,
   input  logic                     tok_in,
   output logic                     tok_out,
   output logic                     wrap_out,
   output scpr_pkg::cell_stat_type  stat
);
   import scpr_pkg::*;

   logic [PAGE_BITS-1:0] page_ff;
   logic                 valid_ff;
   logic                 visited_ff;
   logic                 token_ff;
   logic                 is_last;
   logic                 match;
   logic                 take;

   assign is_last = (last_idx == SLOT_W'(IDX));
   assign match   = valid_ff && (page_ff == page_in);
   // The hand stops on this cell when it holds the token and was not visited.
   assign take    = cmd.sweep && token_ff && !visited_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff   <= 1'b0;
         visited_ff <= 1'b0;
         token_ff   <= (IDX == 0);
      end else begin
         if (cmd.compare && match) begin
            visited_ff <= 1'b1;
         end
         if (cmd.sweep) begin
            if (token_ff) begin
               visited_ff <= 1'b0;
            end
            if (take) begin
               valid_ff <= 1'b1;
            end
            token_ff <= tok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         page_ff <= page_in;
      end
   end

   assign tok_out        = token_ff && !is_last;
   assign wrap_out       = token_ff && is_last;
   assign stat.match     = match;
   assign stat.found     = token_ff && !visited_ff;
   assign stat.occupied  = token_ff && valid_ff;

endmodule

@@ sv/second_chance_page_replacement_unit.sv @@
// Second-chance (CLOCK) page replacement unit: a request carries one page number and
// yields one response with hit, the slot now holding the page, and the evicted page.
// All in-use slots are compared at once; on a fault a one-hot hand token steps along
// the row of cells one slot per cycle, clearing visited bits until it meets a clear
// one. Requests are taken one at a time: a hit passes through the compare and emit
// states, a fault through compare, sweep, evict and emit, where the sweep clears the
// visited bits the hand meets on its way (at most the capacity). A capacity write
// empties the table at once; there is no clearing pass after reset. A response may
// wait on rsp_ready while the next request is already being worked on.
module second_chance_page_replacement_unit #(
   parameter int FRAMES    = scpr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = scpr_pkg::PAGE_BITS_DEF,
   localparam int SLOT_W   = $clog2(FRAMES)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [PAGE_BITS-1:0]            req_page,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic [SLOT_W-1:0]               rsp_slot,
   output logic                            rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]            rsp_evicted_page,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [scpr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [scpr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [scpr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import scpr_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_COMPARE = 3'd1;
   localparam logic [2:0] ST_SWEEP   = 3'd2;
   localparam logic [2:0] ST_EVICT   = 3'd3;
   localparam logic [2:0] ST_EMIT    = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [PAGE_BITS-1:0] page_ff;
   logic [SLOT_W-1:0]    hand_ff, hand_in;
   logic [SLOT_W-1:0]    last_ff, last_in;
   logic [CAP_W-1:0]     cap_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic                 evv_ff;
   logic                 res_hit_ff;
   logic [SLOT_W-1:0]    res_slot_ff;
   logic                 res_evv_ff;
   logic [PAGE_BITS-1:0] res_evp_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_evv_ff;
   logic [PAGE_BITS-1:0] rsp_evp_ff;

   cell_cmd_type         cmd;
   cell_stat_type        stat [FRAMES];
   logic [FRAMES:0]      tok_link;
   logic [FRAMES-1:0]    wrap_vec;
   logic [FRAMES-1:0]    match_vec;
   logic [FRAMES-1:0]    found_vec;
   logic [FRAMES-1:0]    occ_vec;
   logic                 hit_any;
   logic                 found;
   logic                 occupied;
   logic [SLOT_W-1:0]    hit_idx;
   logic                 cfg_wr;
   logic [31:0]          cap_ext;
   logic                 accept;
   logic                 emit;
   logic                 ram_rd_en;
   logic                 ram_wr_en;
   logic [PAGE_BITS-1:0] ram_rd_data;

   assign accept  = req_valid && req_ready;
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                    (csr_paddr[CSR_ADDR_W-1] == REG_CAPACITY);

   assign cmd.clear   = cfg_wr;
   assign cmd.compare = (state_ff == ST_COMPARE);
   assign cmd.sweep   = (state_ff == ST_SWEEP);

   // The token leaving the last slot in use re-enters at slot 0.
   assign tok_link[0] = (|wrap_vec) || tok_link[FRAMES];

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      scpr_cell #(
         .IDX       (i),
         .PAGE_BITS (PAGE_BITS),
         .SLOT_W    (SLOT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .page_in  (page_ff),
         .last_idx (last_ff),
         .tok_in   (tok_link[i]),
         .tok_out  (tok_link[i+1]),
         .wrap_out (wrap_vec[i]),
         .stat     (stat[i])
      );
      assign match_vec[i] = stat[i].match;
      assign found_vec[i] = stat[i].found;
      assign occ_vec[i]   = stat[i].occupied;
   end

   assign hit_any  = |match_vec;
   assign found    = |found_vec;
   assign occupied = |occ_vec;

   // At most one valid slot holds a given page, so the index bits can be ORed.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (match_vec[i]) begin
            hit_idx = hit_idx | SLOT_W'(i);
         end
      end
   end

   assign ram_rd_en = (state_ff == ST_SWEEP) && found;
   assign ram_wr_en = (state_ff == ST_EVICT);

   scpr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (page_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (hand_ff),
      .rd_data (ram_rd_data)
   );

   // Capacity of zero acts as one, and anything above FRAMES saturates.
   always_comb begin
      cap_ext = 32'(csr_pwdata[CAP_W-1:0]);
      if (cap_ext == 32'd0) begin
         last_in = '0;
      end else if (cap_ext >= 32'(FRAMES)) begin
         last_in = SLOT_W'(FRAMES - 1);
      end else begin
         last_in = SLOT_W'(cap_ext - 32'd1);
      end
   end

   assign emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      hand_in  = hand_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = hit_any ? ST_EMIT : ST_SWEEP;
         end
         ST_SWEEP: begin
            hand_in = (hand_ff == last_ff) ? '0 : hand_ff + SLOT_W'(1);
            if (found) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hand_ff      <= '0;
         last_ff      <= SLOT_W'(FRAMES - 1);
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            cap_ff  <= csr_pwdata[CAP_W-1:0];
            last_ff <= last_in;
            hand_ff <= '0;
         end else begin
            hand_ff <= hand_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_page;
      end
      if (ram_rd_en) begin
         slot_ff <= hand_ff;
         evv_ff  <= occupied;
      end
      if ((state_ff == ST_COMPARE) && hit_any) begin
         res_hit_ff  <= 1'b1;
         res_slot_ff <= hit_idx;
         res_evv_ff  <= 1'b0;
         res_evp_ff  <= '0;
      end
      if (state_ff == ST_EVICT) begin
         res_hit_ff  <= 1'b0;
         res_slot_ff <= slot_ff;
         res_evv_ff  <= evv_ff;
         res_evp_ff  <= evv_ff ? ram_rd_data : '0;
      end
      if (emit) begin
         rsp_hit_ff  <= res_hit_ff;
         rsp_slot_ff <= res_slot_ff;
         rsp_evv_ff  <= res_evv_ff;
         rsp_evp_ff  <= res_evp_ff;
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_evv_ff;
   assign rsp_evicted_page  = rsp_evp_ff;
   assign csr_pready        = 1'b1;
   assign csr_prdata        = (csr_paddr[CSR_ADDR_W-1] == REG_CAPACITY) ?
                              CSR_DATA_W'(cap_ff) : '0;

endmodule

@@ sv/scpr_checker.sv @@
// Port-level checks of the second-chance page replacement unit, bound to the top level.
module scpr_checker #(
   parameter int FRAMES    = scpr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = scpr_pkg::PAGE_BITS_DEF,
   localparam int SLOT_W   = $clog2(FRAMES)
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_hit,
   input logic [SLOT_W-1:0]               rsp_slot,
   input logic                            rsp_evicted_valid,
   input logic [PAGE_BITS-1:0]            rsp_evicted_page
);

   // A stalled response keeps its slot, hit flag and evicted page.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_hit) &&
                                  $stable(rsp_evicted_page))
      else $error("stalled response changed");

   // A hit never reports an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid)
      else $error("hit reported an eviction");

   // Without an eviction the evicted page reads as zero.
   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> (rsp_evicted_page == '0))
      else $error("evicted page not zero without eviction");

   // Requests are worked on one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

endmodule

bind second_chance_page_replacement_unit scpr_checker #(
   .FRAMES    (FRAMES),
   .PAGE_BITS (PAGE_BITS)
) u_scpr_checker (.*);

@@ test/second_chance_page_replacement_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the second-chance page replacement unit.
module second_chance_page_replacement_unit_tb;
   import scpr_pkg::*;

   localparam int FRAMES       = 64;
   localparam int PAGE_BITS    = 20;
   localparam int SLOT_W       = 6;
   localparam int GAP_MAX      = 17;
   localparam int IDLE_LIMIT   = 4000;
   localparam int RANDOM_ITEMS = 950;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

   typedef struct packed {
      logic                 hit;
      logic [SLOT_W-1:0]    slot;
      logic                 evicted_valid;
      logic [PAGE_BITS-1:0] evicted_page;
   } access_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PAGE_BITS-1:0]  req_page = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_hit;
   logic [SLOT_W-1:0]     rsp_slot;
   logic                  rsp_evicted_valid;
   logic [PAGE_BITS-1:0]  rsp_evicted_page;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   second_chance_page_replacement_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: what each frame holds and where the hand points.
   logic [PAGE_BITS-1:0] resident_page [FRAMES];
   logic                 resident_valid [FRAMES];
   logic                 referenced [FRAMES];
   int                   hand;
   int                   frames_used;

   function automatic void set_capacity(input logic [CAP_W-1:0] value);
      frames_used = (value == 0) ? 1 : (value > FRAMES) ? FRAMES : int'(value);
      for (int i = 0; i < FRAMES; i++) begin
         resident_page[i]  = '0;
         resident_valid[i] = 1'b0;
         referenced[i]     = 1'b0;
      end
      hand = 0;
   endfunction

   function automatic access_outcome_type predict_access(input logic [PAGE_BITS-1:0] page);
      access_outcome_type res;
      int h;
      res = '0;
      for (int i = 0; i < frames_used; i++) begin
         if (resident_valid[i] && resident_page[i] == page) begin
            referenced[i] = 1'b1;
            res.hit = 1'b1;
            res.slot = i[SLOT_W-1:0];
            return res;
         end
      end
      h = (hand >= frames_used) ? 0 : hand;
      // The sweep gives every referenced frame a second chance before taking it.
      for (int n = 0; n <= frames_used && referenced[h]; n++) begin
         referenced[h] = 1'b0;
         h = (h + 1) % frames_used;
      end
      res.slot = h[SLOT_W-1:0];
      res.evicted_valid = resident_valid[h];
      if (resident_valid[h]) res.evicted_page = resident_page[h];
      resident_page[h]  = page;
      resident_valid[h] = 1'b1;
      referenced[h]     = 1'b0;
      hand = (h + 1) % frames_used;
      return res;
   endfunction

   logic [PAGE_BITS-1:0] pending_pages[$];
   access_outcome_type   expected_outcomes[$];
   int                   issued_count = 0;
   int                   accepted_count = 0;
   int                   mismatches = 0;
   int                   req_gap_max = GAP_MAX;
   int                   rsp_stall_max = GAP_MAX;
   int                   req_gap_left = 0;
   int                   rsp_wait_left = 0;
   int                   idle_cycles = 0;

   // Request driver: after each accepted request it idles for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left <= 0;
      end else if (!req_valid || req_ready) begin : drive
         int wait_now;
         wait_now = req_valid ? int'($urandom_range(0, req_gap_max)) : req_gap_left;
         if (wait_now == 0 && pending_pages.size() != 0) begin
            req_valid <= 1'b1;
            req_page <= pending_pages.pop_front();
            req_gap_left <= 0;
         end else begin
            req_valid <= 1'b0;
            req_gap_left <= (wait_now > 0) ? wait_now - 1 : 0;
         end
      end
   end

   // Monitor: predicts on every accepted request and checks every accepted response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait_left <= 0;
      end else begin : watch
         access_outcome_type got;
         access_outcome_type want;
         int draw;
         if (req_valid && req_ready) begin
            expected_outcomes.push_back(predict_access(req_page));
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_hit, rsp_slot, rsp_evicted_valid, rsp_evicted_page};
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no request pending: hit=%0b slot=%0d", $realtime,
                           got.hit, got.slot);
            end else begin
               want = expected_outcomes.pop_front();
               if (got.hit !== want.hit || got.slot !== want.slot ||
                   got.evicted_valid !== want.evicted_valid ||
                   got.evicted_page !== want.evicted_page) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected %0b %0d %0b %h, got %0b %0d %0b %h",
                              $realtime, want.hit, want.slot, want.evicted_valid,
                              want.evicted_page, got.hit, got.slot, got.evicted_valid,
                              got.evicted_page);
               end
            end
            draw = $urandom_range(0, rsp_stall_max);
            rsp_ready <= (draw == 0);
            rsp_wait_left <= draw;
         end else if (rsp_wait_left > 0) begin
            rsp_ready <= (rsp_wait_left == 1);
            rsp_wait_left <= rsp_wait_left - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_page(input logic [PAGE_BITS-1:0] page);
      pending_pages.push_back(page);
      issued_count++;
   endtask

   // Waits until every request is accepted and every response has been checked.
   task automatic drain();
      while (accepted_count != issued_count || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CAPACITY_ADDR;
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      set_capacity(value);
   endtask

   initial begin
      logic [PAGE_BITS-1:0] pool[$];
      logic [PAGE_BITS-1:0] page;
      logic [CAP_W-1:0]     new_cap;
      int                   random_sent;
      int                   batch;
      int                   idx;

      set_capacity(CAP_RESET);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity: an empty frame never matches page zero; extremes of the page field.
      queue_page(20'h00000);
      queue_page(20'h00000);
      queue_page(20'hFFFFF);
      queue_page(20'hFFFFF);
      queue_page(20'h5A5A5);
      drain();

      // A capacity of zero behaves as a single frame.
      write_capacity(7'd0);
      queue_page(20'h00001);
      queue_page(20'h00001);
      queue_page(20'h80000);
      drain();

      // Two frames, both referenced: the hand clears a full turn before it replaces.
      write_capacity(7'd2);
      queue_page(20'h12345);
      queue_page(20'hEDCBA);
      queue_page(20'h12345);
      queue_page(20'hEDCBA);
      queue_page(20'h0F0F0);
      queue_page(20'h12345);
      drain();

      // A capacity above the frame count saturates.
      write_capacity(7'd127);
      queue_page(20'h00000);
      queue_page(20'h7FFFF);
      queue_page(20'h00000);
      drain();

      write_capacity(7'd64);
      queue_page(20'hAAAAA);
      queue_page(20'h55555);
      queue_page(20'hAAAAA);
      drain();

      // Random phases: a working set a little larger than the table, with some fresh pages.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
               0: new_cap = 7'd1;
               1: new_cap = 7'd2;
               2: new_cap = 7'd64;
               3: new_cap = 7'd0;
               4: new_cap = 7'd127;
               5: new_cap = 7'($urandom_range(1, 8));
               default: new_cap = 7'($urandom_range(1, 64));
            endcase
            write_capacity(new_cap);
         end
         req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
         rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
         pool.delete();
         repeat (frames_used + $urandom_range(0, frames_used / 2 + 2))
            pool.push_back(20'($urandom_range(0, 20'hFFFFF)));
         batch = $urandom_range(30, 90);
         repeat (batch) begin
            idx = $urandom_range(0, pool.size() - 1);
            if ($urandom_range(0, 99) < 85) begin
               page = pool[idx];
            end else begin
               page = 20'($urandom_range(0, 20'hFFFFF));
               pool[idx] = page;
            end
            queue_page(page);
         end
         random_sent += batch;
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_outcomes.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/scpr_pkg.sv
sv/scpr_ram.sv
sv/scpr_cell.sv
sv/second_chance_page_replacement_unit.sv
sv/scpr_checker.sv
test/second_chance_page_replacement_unit_tb.sv
